// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// File: rtl/watm_pkg.sv
// ----------------------------------------------------------------------------
// watm_pkg
// shared types and constants of the windowed average threshold monitor
// ----------------------------------------------------------------------------
`default_nettype none

package watm_pkg;

	localparam int TEMP_W     = 11;
	localparam int HUM_W      = 10;
	localparam int LEVEL_W    = 10;
	localparam int HEALTH_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_LOW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_HIGH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_HIGH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VIB_HIGH   = 3'd6;

	// limit reset values
	localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST   = 11'sd150;
	localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST  = 11'sd350;
	localparam logic [HUM_W-1:0]         HUM_LOW_RST    = 10'd300;
	localparam logic [HUM_W-1:0]         HUM_HIGH_RST   = 10'd700;
	localparam logic [LEVEL_W-1:0]       LIGHT_LOW_RST  = 10'd200;
	localparam logic [LEVEL_W-1:0]       LIGHT_HIGH_RST = 10'd800;
	localparam logic [LEVEL_W-1:0]       VIB_HIGH_RST   = 10'd500;

	// health codes
	localparam logic [HEALTH_W-1:0] HEALTH_NORMAL    = 2'd0;
	localparam logic [HEALTH_W-1:0] HEALTH_ATTENTION = 2'd1;
	localparam logic [HEALTH_W-1:0] HEALTH_CRITICAL  = 2'd2;

	typedef struct packed {
		logic load;
		logic update;
		logic setup;
		logic div_step;
		logic publish;
	} watm_cmd_t;

	typedef struct packed {
		logic div_last;
	} watm_sts_t;

endpackage

`default_nettype wire

// File: rtl/watm_ram.sv
// ----------------------------------------------------------------------------
// watm_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module watm_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/watm_dp.sv
// ----------------------------------------------------------------------------
// watm_dp
// datapath: limit registers, sample ring, running sums, bit serial dividers,
// threshold checks and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module watm_dp import watm_pkg::*; #(
	parameter int WINDOW_LEN = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire watm_cmd_t              cmd,
	output watm_sts_t                   sts,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic signed [TEMP_W-1:0] temperature,
	input  wire logic [HUM_W-1:0]       humidity,
	input  wire logic [LEVEL_W-1:0]     light_level,
	input  wire logic [LEVEL_W-1:0]     vibration_level,
	output logic signed [TEMP_W-1:0]    avg_temperature,
	output logic [HUM_W-1:0]            avg_humidity,
	output logic                        temp_alert,
	output logic                        hum_alert,
	output logic                        light_alert,
	output logic                        vib_alert,
	output logic [HEALTH_W-1:0]         health_status
);

	localparam int AW      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int CW      = $clog2(WINDOW_LEN + 1);
	localparam int TSW     = TEMP_W + CW;
	localparam int DW      = HUM_W + CW;
	localparam int SW      = $clog2(DW + 1);
	localparam int ENTRY_W = TEMP_W + HUM_W;

	// limits
	logic signed [TEMP_W-1:0] temp_low_q, temp_high_q;
	logic [HUM_W-1:0]         hum_low_q, hum_high_q;
	logic [LEVEL_W-1:0]       light_low_q, light_high_q, vib_high_q;

	// current sample
	logic signed [TEMP_W-1:0] samp_t_q;
	logic [HUM_W-1:0]         samp_h_q;
	logic [LEVEL_W-1:0]       samp_l_q, samp_v_q;

	// window state
	logic signed [TSW-1:0]    tsum_q, tsum_nx;
	logic [DW-1:0]            hsum_q, hsum_nx;
	logic [AW-1:0]            slot_q;
	logic [CW-1:0]            fill_q;
	logic                     full;
	logic [ENTRY_W-1:0]       ram_rdata;
	logic signed [TEMP_W-1:0] old_t;
	logic [HUM_W-1:0]         old_h;

	// dividers
	logic [DW-1:0]            t_quo_q, h_quo_q;
	logic [CW-1:0]            t_rem_q, h_rem_q, div_q;
	logic                     t_neg_q;
	logic [SW-1:0]            step_q;
	logic [TSW-1:0]           t_mag;
	logic [CW:0]              t_sh, h_sh;
	logic                     t_ge, h_ge;
	logic [CW-1:0]            t_rem_nx, h_rem_nx;

	// checks
	logic                     ta, ha, la, va;
	logic [2:0]               n_alerts;
	logic [HEALTH_W-1:0]      health;

	watm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (WINDOW_LEN),
		.ADDR_W(AW)
	) u_ring (
		.clk  (clk),
		.we   (cmd.update),
		.waddr(slot_q),
		.wdata({samp_t_q, samp_h_q}),
		.raddr(slot_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_low_q   <= TEMP_LOW_RST;
			temp_high_q  <= TEMP_HIGH_RST;
			hum_low_q    <= HUM_LOW_RST;
			hum_high_q   <= HUM_HIGH_RST;
			light_low_q  <= LIGHT_LOW_RST;
			light_high_q <= LIGHT_HIGH_RST;
			vib_high_q   <= VIB_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEMP_LOW:   temp_low_q   <= cfg_data[TEMP_W-1:0];
				REG_TEMP_HIGH:  temp_high_q  <= cfg_data[TEMP_W-1:0];
				REG_HUM_LOW:    hum_low_q    <= cfg_data[HUM_W-1:0];
				REG_HUM_HIGH:   hum_high_q   <= cfg_data[HUM_W-1:0];
				REG_LIGHT_LOW:  light_low_q  <= cfg_data[LEVEL_W-1:0];
				REG_LIGHT_HIGH: light_high_q <= cfg_data[LEVEL_W-1:0];
				REG_VIB_HIGH:   vib_high_q   <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			samp_t_q <= temperature;
			samp_h_q <= humidity;
			samp_l_q <= light_level;
			samp_v_q <= vibration_level;
		end
	end

	assign old_t = ram_rdata[ENTRY_W-1:HUM_W];
	assign old_h = ram_rdata[HUM_W-1:0];
	assign full  = (fill_q == CW'(WINDOW_LEN));

	// oldest entry leaves the sum only once the window is full
	always_comb begin
		tsum_nx = tsum_q + TSW'(samp_t_q) - (full ? TSW'(old_t) : TSW'(0));
		hsum_nx = hsum_q + DW'(samp_h_q) - (full ? DW'(old_h) : DW'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsum_q <= '0;
			hsum_q <= '0;
			slot_q <= '0;
			fill_q <= '0;
		end else if (cmd.update) begin
			tsum_q <= tsum_nx;
			hsum_q <= hsum_nx;
			slot_q <= (slot_q == AW'(WINDOW_LEN - 1)) ? AW'(0) : slot_q + AW'(1);
			if (!full) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	// restoring division, one quotient bit per step
	always_comb begin
		t_mag    = tsum_q[TSW-1] ? TSW'(-tsum_q) : TSW'(tsum_q);
		t_sh     = {t_rem_q, t_quo_q[DW-1]};
		h_sh     = {h_rem_q, h_quo_q[DW-1]};
		t_ge     = (t_sh >= {1'b0, div_q});
		h_ge     = (h_sh >= {1'b0, div_q});
		t_rem_nx = t_ge ? CW'(t_sh - {1'b0, div_q}) : t_sh[CW-1:0];
		h_rem_nx = h_ge ? CW'(h_sh - {1'b0, div_q}) : h_sh[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.setup) begin
			step_q <= SW'(DW);
		end else if (cmd.div_step) begin
			step_q <= step_q - SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			t_neg_q <= tsum_q[TSW-1];
			t_quo_q <= t_mag[DW-1:0];
			h_quo_q <= hsum_q;
			t_rem_q <= '0;
			h_rem_q <= '0;
			div_q   <= fill_q;
		end else if (cmd.div_step) begin
			t_quo_q <= {t_quo_q[DW-2:0], t_ge};
			h_quo_q <= {h_quo_q[DW-2:0], h_ge};
			t_rem_q <= t_rem_nx;
			h_rem_q <= h_rem_nx;
		end
	end

	assign sts.div_last = (step_q == SW'(1));

	always_comb begin
		ta = (samp_t_q < temp_low_q) || (samp_t_q > temp_high_q);
		ha = (samp_h_q < hum_low_q) || (samp_h_q > hum_high_q);
		la = (samp_l_q < light_low_q) || (samp_l_q > light_high_q);
		va = (samp_v_q > vib_high_q);
		n_alerts = {2'b00, ta} + {2'b00, ha} + {2'b00, la} + {2'b00, va};
		if (n_alerts == 3'd0) begin
			health = HEALTH_NORMAL;
		end else if (n_alerts <= 3'd2) begin
			health = HEALTH_ATTENTION;
		end else begin
			health = HEALTH_CRITICAL;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			avg_temperature <= t_neg_q ? -t_quo_q[TEMP_W-1:0] : t_quo_q[TEMP_W-1:0];
			avg_humidity    <= h_quo_q[HUM_W-1:0];
			temp_alert      <= ta;
			hum_alert       <= ha;
			light_alert     <= la;
			vib_alert       <= va;
			health_status   <= health;
		end
	end

endmodule

`default_nettype wire

// File: rtl/watm_ctrl.sv
// ----------------------------------------------------------------------------
// watm_ctrl
// controller: sequences read, update, setup, divide and publish for each request
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module watm_ctrl import watm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	output watm_cmd_t      cmd,
	input  wire watm_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_SETUP,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.update   = (state_q == ST_UPDATE);
		cmd.setup    = (state_q == ST_SETUP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.publish  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ:   state_q <= ST_UPDATE;
				ST_UPDATE: state_q <= ST_SETUP;
				ST_SETUP:  state_q <= ST_DIV;
				ST_DIV: begin
					if (sts.div_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.publish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEVER(a_no_overwrite, cmd.publish && out_valid_q && out_stall, "result overwritten while held")
	`ASSERT_CLK(a_accept_read, (in_valid && !in_stall) |=> (state_q == ST_READ), "request not started")
	`ASSERT_CLK(a_div_hold, (state_q == ST_DIV && !sts.div_last) |=> (state_q == ST_DIV), "divide cut short")
	`ASSERT_CLK(a_valid_src, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "result without divide")

endmodule

`default_nettype wire

// File: rtl/windowed_average_threshold_monitor.sv
// Moving average and threshold monitor for one sensor reading per request. Each request
// returns exactly one result. The result holds the window averages of temperature and
// humidity and four limit alerts with a summary health code. A request passes through
// the ring read, the sum update, the divider setup, the divide and the publish, in that
// order. The divide uses a pair of restoring dividers, which retire one quotient bit per
// cycle and are DW = 10 + clog2(WINDOW_LEN + 1) bits wide. The publish waits while a
// held result is stalled. The next request is accepted as soon as the result sits in
// the output register, so a new request is not taken before the last one is through.
// ----------------------------------------------------------------------------
// windowed_average_threshold_monitor
// top level: controller plus datapath
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_average_threshold_monitor import watm_pkg::*; #(
	parameter int WINDOW_LEN = 12
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [TEMP_W-1:0] temperature,
	input  wire logic [HUM_W-1:0]         humidity,
	input  wire logic [LEVEL_W-1:0]       light_level,
	input  wire logic [LEVEL_W-1:0]       vibration_level,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [TEMP_W-1:0]      avg_temperature,
	output logic [HUM_W-1:0]              avg_humidity,
	output logic                          temp_alert,
	output logic                          hum_alert,
	output logic                          light_alert,
	output logic                          vib_alert,
	output logic [HEALTH_W-1:0]           health_status
);

	watm_cmd_t cmd;
	watm_sts_t sts;

	watm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	watm_dp #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.temperature    (temperature),
		.humidity       (humidity),
		.light_level    (light_level),
		.vibration_level(vibration_level),
		.avg_temperature(avg_temperature),
		.avg_humidity   (avg_humidity),
		.temp_alert     (temp_alert),
		.hum_alert      (hum_alert),
		.light_alert    (light_alert),
		.vib_alert      (vib_alert),
		.health_status  (health_status)
	);

endmodule

`default_nettype wire

// File: tb/windowed_average_threshold_monitor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_average_threshold_monitor_test
// self-checking bench: sends sensor readings under random idling on both
// channels, predicts window averages, limit alerts and health for each
// request, and checks every result in order across several limit settings
// ----------------------------------------------------------------------------

module windowed_average_threshold_monitor_test import watm_pkg::*;;

	localparam int WINDOW         = 12;
	localparam int SETTLE_CYCLES  = 24;
	localparam int DRAIN_CYCLES   = 30;
	localparam int WATCHDOG_LIMIT = 400;
	localparam int PHASE_ITEMS    = 200;
	localparam int PHASES         = 6;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	typedef struct {
		logic signed [TEMP_W-1:0] avg_temp;
		logic [HUM_W-1:0]         avg_hum;
		logic                     temp_flag;
		logic                     hum_flag;
		logic                     light_flag;
		logic                     vib_flag;
		logic [HEALTH_W-1:0]      health;
	} monitor_summary_t;

	class reading_scoreboard;
		int temp_lo, temp_hi, hum_lo, hum_hi, light_lo, light_hi, vib_hi;
		int temp_hist[WINDOW];
		int hum_hist[WINDOW];
		int temp_sum, hum_sum, slot, fill;
		monitor_summary_t pending_summaries[$];
		int errors, readings;
		int status_hits[3];

		function new();
			temp_lo  = TEMP_LOW_RST;
			temp_hi  = TEMP_HIGH_RST;
			hum_lo   = HUM_LOW_RST;
			hum_hi   = HUM_HIGH_RST;
			light_lo = LIGHT_LOW_RST;
			light_hi = LIGHT_HIGH_RST;
			vib_hi   = VIB_HIGH_RST;
		endfunction

		function int pending();
			return pending_summaries.size();
		endfunction

		function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_TEMP_LOW:   temp_lo  = $signed(data[TEMP_W-1:0]);
			REG_TEMP_HIGH:  temp_hi  = $signed(data[TEMP_W-1:0]);
			REG_HUM_LOW:    hum_lo   = data[HUM_W-1:0];
			REG_HUM_HIGH:   hum_hi   = data[HUM_W-1:0];
			REG_LIGHT_LOW:  light_lo = data[LEVEL_W-1:0];
			REG_LIGHT_HIGH: light_hi = data[LEVEL_W-1:0];
			REG_VIB_HIGH:   vib_hi   = data[LEVEL_W-1:0];
			default: ;
			endcase
		endfunction

		function void note_reading(logic signed [TEMP_W-1:0] t, logic [HUM_W-1:0] h,
				logic [LEVEL_W-1:0] l, logic [LEVEL_W-1:0] v);
			monitor_summary_t s;
			int tv, hv, lv, vv, alerts;
			tv = t;
			hv = h;
			lv = l;
			vv = v;
			// oldest sample drops out only once the window is full
			if (fill == WINDOW) begin
				temp_sum -= temp_hist[slot];
				hum_sum -= hum_hist[slot];
			end
			temp_hist[slot] = tv;
			hum_hist[slot] = hv;
			temp_sum += tv;
			hum_sum += hv;
			slot = (slot == WINDOW - 1) ? 0 : slot + 1;
			if (fill < WINDOW)
				fill++;
			s.avg_temp = TEMP_W'(temp_sum / fill);
			s.avg_hum = HUM_W'(hum_sum / fill);
			s.temp_flag = (tv < temp_lo) || (tv > temp_hi);
			s.hum_flag = (hv < hum_lo) || (hv > hum_hi);
			s.light_flag = (lv < light_lo) || (lv > light_hi);
			s.vib_flag = vv > vib_hi;
			alerts = int'(s.temp_flag) + int'(s.hum_flag) + int'(s.light_flag)
				+ int'(s.vib_flag);
			if (alerts == 0)
				s.health = HEALTH_NORMAL;
			else if (alerts <= 2)
				s.health = HEALTH_ATTENTION;
			else
				s.health = HEALTH_CRITICAL;
			status_hits[s.health]++;
			readings++;
			pending_summaries.push_back(s);
		endfunction

		function void compare_field(string name, logic signed [11:0] want,
				logic signed [11:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(monitor_summary_t got);
			monitor_summary_t want;
			if (pending_summaries.size() == 0) begin
				errors++;
				$display("%0t: result with no reading outstanding, expected none, got avg %0d",
					$time, got.avg_temp);
				return;
			end
			want = pending_summaries.pop_front();
			compare_field("avg_temperature", $signed(want.avg_temp), $signed(got.avg_temp));
			compare_field("avg_humidity", want.avg_hum, got.avg_hum);
			compare_field("temp_alert", want.temp_flag, got.temp_flag);
			compare_field("hum_alert", want.hum_flag, got.hum_flag);
			compare_field("light_alert", want.light_flag, got.light_flag);
			compare_field("vib_alert", want.vib_flag, got.vib_flag);
			compare_field("health_status", want.health, got.health);
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n          = 1'b0;
	logic                     cfg_we          = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index       = '0;
	logic [CFG_DATA_W-1:0]    cfg_data        = '0;
	logic                     in_valid        = 1'b0;
	logic                     in_stall;
	logic signed [TEMP_W-1:0] temperature     = '0;
	logic [HUM_W-1:0]         humidity        = '0;
	logic [LEVEL_W-1:0]       light_level     = '0;
	logic [LEVEL_W-1:0]       vibration_level = '0;
	logic                     out_valid;
	logic                     out_stall       = 1'b0;
	logic signed [TEMP_W-1:0] avg_temperature;
	logic [HUM_W-1:0]         avg_humidity;
	logic                     temp_alert;
	logic                     hum_alert;
	logic                     light_alert;
	logic                     vib_alert;
	logic [HEALTH_W-1:0]      health_status;

	reading_scoreboard board = new();
	int gap_rate   = 0;
	int stall_rate = 0;
	int quiet_cycles = 0;

	windowed_average_threshold_monitor #(.WINDOW_LEN(WINDOW)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin : observe
		monitor_summary_t got;
		if (arst_n && in_valid && !in_stall)
			board.note_reading(temperature, humidity, light_level, vibration_level);
		if (arst_n && out_valid && !out_stall) begin
			got.avg_temp = avg_temperature;
			got.avg_hum = avg_humidity;
			got.temp_flag = temp_alert;
			got.hum_flag = hum_alert;
			got.light_flag = light_alert;
			got.vib_flag = vib_alert;
			got.health = health_status;
			board.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d results outstanding",
				$time, WATCHDOG_LIMIT, board.pending());
			$display("windowed_average_threshold_monitor verification failed");
			$finish;
		end
	end

	// result side back-pressure in random bursts
	initial begin
		forever begin
			@(posedge clk);
			if (stall_rate != 0 && $urandom_range(0, 9) < stall_rate) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_reading(int t, int h, int l, int v);
		if (gap_rate != 0 && $urandom_range(0, 9) < gap_rate) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		temperature <= t[TEMP_W-1:0];
		humidity <= h[HUM_W-1:0];
		light_level <= l[LEVEL_W-1:0];
		vibration_level <= v[LEVEL_W-1:0];
		do @(posedge clk); while (in_stall);
	endtask

	// limits change only with the block idle and every result back
	task automatic apply_limits(int lim[7]);
		logic [CFG_DATA_W-1:0] data;
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int i = 0; i <= REG_NONE; i++) begin
			if (i == REG_NONE)
				data = CFG_DATA_W'($urandom);
			else
				data = CFG_DATA_W'(lim[i]);
			// upper data bit is don't-care for the 10-bit registers
			if (i != REG_TEMP_LOW && i != REG_TEMP_HIGH && $urandom_range(0, 1))
				data[CFG_DATA_W-1] = 1'b1;
			cfg_we <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= data;
			board.set_limit(i[CFG_IDX_W-1:0], data);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic void random_pair(output int lo, output int hi, input int fmin,
			input int fmax);
		int a, b;
		a = fmin + int'($urandom_range(0, fmax - fmin));
		b = fmin + int'($urandom_range(0, fmax - fmin));
		// mostly ordered, sometimes crossed
		if (a > b && $urandom_range(0, 4) != 0) begin
			lo = b;
			hi = a;
		end else begin
			lo = a;
			hi = b;
		end
	endfunction

	function automatic int pick_value(int lo_lim, int hi_lim, int fmin, int fmax);
		int v, lo, hi;
		lo = (lo_lim < hi_lim) ? lo_lim : hi_lim;
		hi = (lo_lim < hi_lim) ? hi_lim : lo_lim;
		case ($urandom_range(0, 9))
		0, 1, 2: v = lo_lim + int'($urandom_range(0, 6)) - 3;
		3, 4, 5: v = hi_lim + int'($urandom_range(0, 6)) - 3;
		6, 7, 8: v = lo + int'($urandom_range(0, hi - lo));
		default: v = fmin + int'($urandom_range(0, fmax - fmin));
		endcase
		if (v < fmin)
			v = fmin;
		if (v > fmax)
			v = fmax;
		return v;
	endfunction

	initial begin : stimulus
		int lim[7];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		gap_rate = 2;
		stall_rate = 2;

		// reset limits: boundaries, every health level, field extremes
		send_reading(250, 500, 500, 100);
		send_reading(150, 300, 200, 500);
		send_reading(350, 700, 800, 0);
		send_reading(149, 500, 500, 100);
		send_reading(351, 299, 500, 100);
		send_reading(250, 701, 199, 501);
		send_reading(-1024, 0, 0, 1023);
		send_reading(1023, 1023, 1023, 1023);
		send_reading(-400, 1000, 801, 501);
		send_reading(800, 0, 1023, 0);
		send_reading(-1, 1023, 0, 0);
		send_reading(-1023, 1, 1, 1);
		// window wraps here; sum goes negative and truncates toward zero
		send_reading(-777, 3, 5, 7);
		send_reading(-1000, 999, 300, 400);
		send_reading(-5, 2, 600, 499);
		send_reading(0, 0, 0, 0);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: lim = '{-1024, 1023, 0, 1023, 0, 1023, 1023};
			1: lim = '{1023, -1024, 1023, 0, 1023, 0, 0};
			PHASES - 1: lim = '{150, 350, 300, 700, 200, 800, 500};
			default: begin
				random_pair(lim[REG_TEMP_LOW], lim[REG_TEMP_HIGH], -1024, 1023);
				random_pair(lim[REG_HUM_LOW], lim[REG_HUM_HIGH], 0, 1023);
				random_pair(lim[REG_LIGHT_LOW], lim[REG_LIGHT_HIGH], 0, 1023);
				lim[REG_VIB_HIGH] = $urandom_range(0, 1023);
			end
			endcase
			if (phase == PHASES - 1) begin
				gap_rate = 0;
				stall_rate = 0;
			end
			apply_limits(lim);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase < PHASES - 1 && n % 40 == 0) begin
					gap_rate = $urandom_range(0, 3);
					stall_rate = $urandom_range(0, 3);
				end
				send_reading(pick_value(board.temp_lo, board.temp_hi, -1024, 1023),
					pick_value(board.hum_lo, board.hum_hi, 0, 1023),
					pick_value(board.light_lo, board.light_hi, 0, 1023),
					pick_value(0, board.vib_hi, 0, 1023));
			end
		end
		in_valid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d readings over %0d limit settings incl. wide open and crossed",
			board.readings, PHASES + 1);
		$display("health normal/attention/critical: %0d/%0d/%0d, mismatches: %0d",
			board.status_hits[HEALTH_NORMAL], board.status_hits[HEALTH_ATTENTION],
			board.status_hits[HEALTH_CRITICAL], board.errors);
		if (board.errors == 0)
			$display("windowed_average_threshold_monitor verification clean");
		else
			$display("windowed_average_threshold_monitor verification failed");
		$finish;
	end

endmodule
